>>> hw/rtl/aps_pkg.sv
`default_nettype none

package aps_pkg;

  // splitmix64 constants
  localparam logic [63:0] MIX_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL2  = 64'h94d049bb133111eb;
  localparam int unsigned MIX_SH1 = 30;
  localparam int unsigned MIX_SH2 = 27;
  localparam int unsigned MIX_SH3 = 31;

  // prime clamp
  localparam logic [4:0] PRIME_MIN = 5'd5;
  localparam logic [4:0] PRIME_MAX = 5'd23;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET = 2'd2;

  typedef struct packed {
    logic advance;
  } req_t;

  typedef struct packed {
    logic [31:0] sample_index;
    logic [4:0]  lambda_value;
    logic [4:0]  y_value;
    logic [4:0]  z_value;
    logic [4:0]  w_value;
    logic [4:0]  digit_zero;
    logic [4:0]  digit_one;
    logic [4:0]  digit_two;
    logic        last_sample;
  } smp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_POW,
    S_SIZE,
    S_CHECK,
    S_MIX_ADD,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_DRAW,
    S_GCD,
    S_GCD_REM,
    S_SPLIT,
    S_UDIV,
    S_DIGIT,
    S_SURF,
    S_ADV,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/aps_chan_if.sv
`default_nettype none

interface aps_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/affine_permutation_sampler.sv
`default_nettype none

// channel    dir  payload                                        transfer
// request    in   advance                                        valid & ready
// sample     out  index, lambda, y, z, w, three digits, last     valid & ready
// cfg        in   cfg_index, cfg_data                            cfg_write high
//
// one request multiplies out the universe size, then runs (6 + min(U_DIGITS, 3))
// divisions, plus the idle, check and output states
// the first request adds two splitmix draws (each ending in a 64-bit division) and a
// gcd search, also run through the single bit-serial divider that sets the rate
// request is ready only in idle; a finished result waits in the output register
// while the next request is worked on
// synchronous active-high reset; no memory, no clearing pass

module affine_permutation_sampler #(
  parameter int unsigned U_DIGITS = 3
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  aps_chan_if.sink                            request,
  aps_chan_if.source                          sample,
  input  wire logic                           cfg_write,
  input  wire logic [aps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [aps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import aps_pkg::*;

  // universe width: 21*22^3 < 2^18, 23^k < 2^(5k)
  localparam int unsigned UW    = 18 + 5 * U_DIGITS;
  localparam int unsigned DIG_N = (U_DIGITS < 3) ? U_DIGITS : 3;
  localparam int unsigned PAD   = 64 - UW;

  // configuration registers
  logic [4:0]  prime_modulus;
  logic [63:0] seed_value;
  logic [31:0] sample_budget;

  // walk state
  state_t      state, state_next, div_ret;
  logic [63:0] rng_state;
  logic [UW-1:0] walk_offset, walk_step, current_index;
  logic [31:0] samples_done, budget;
  logic        started_flag, draw;

  // size and decode work registers
  logic [UW-1:0] ucnt, uni, gx, gm, idx, sc;
  logic [2:0]    mcnt;
  logic [1:0]    dcnt;
  logic [4:0]    digits [3];
  logic [4:0]    surf [3];
  logic [4:0]    lambda;
  logic          last;

  // 64x16 multiplier for splitmix
  logic [63:0] mul_a, acc, nacc, mul_const;
  logic [79:0] mul_prod;
  logic [15:0] mul_chunk;

  // shared bit-serial divider
  logic [63:0]   div_q;
  logic [UW-1:0] div_r, div_d;
  logic [6:0]    div_cnt;
  logic [UW:0]   div_sh, div_diff;
  logic          div_ge;

  // launch control
  logic          div_load, div_long;
  logic [63:0]   div_num;
  logic [UW-1:0] div_den;
  state_t        div_to;

  // output register
  logic out_valid;
  smp_t out_data;

  logic [4:0]     p_eff, q_val, pm2;
  logic [UW+4:0]  pow_prod, size_prod;
  logic [31:0]    bud_cl;
  logic           exhausted, req_go, out_free;
  logic [63:0]    mix_sum, mix_out;
  logic [UW:0]    adv_sum;
  logic [UW-1:0]  adv_next;

  // clamped prime and its neighbors
  always_comb begin
    if (prime_modulus < PRIME_MIN) begin
      p_eff = PRIME_MIN;
    end else if (prime_modulus > PRIME_MAX) begin
      p_eff = PRIME_MAX;
    end else begin
      p_eff = prime_modulus;
    end
    q_val = p_eff - 5'd1;
    pm2   = p_eff - 5'd2;
  end

  assign pow_prod  = ucnt * p_eff;
  assign size_prod = (mcnt == 3'd0) ? ucnt * pm2 : uni * q_val;

  // budget clamped to the universe
  assign bud_cl    = (64'(uni) < 64'(sample_budget)) ? 32'(uni) : sample_budget;
  assign exhausted = (samples_done >= bud_cl);

  assign req_go   = request.valid && request.ready && request.payload.advance;
  assign out_free = !out_valid || sample.ready;

  // splitmix multiply, one 16-bit slice of the constant per cycle
  assign mix_sum   = rng_state + MIX_GAMMA;
  assign mul_const = (state == S_MUL1) ? MIX_MUL1 : MIX_MUL2;
  assign mul_chunk = mul_const[{mcnt[1:0], 4'b0000} +: 16];
  assign mul_prod  = mul_a * mul_chunk;
  assign nacc      = acc + (mul_prod[63:0] << {mcnt[1:0], 4'b0000});
  assign mix_out   = nacc ^ (nacc >> MIX_SH3);

  // restoring division step
  assign div_sh   = {div_r, div_q[63]};
  assign div_ge   = (div_sh >= {1'b0, div_d});
  assign div_diff = div_sh - {1'b0, div_d};

  // index advance, both terms below the universe
  assign adv_sum  = {1'b0, idx} + {1'b0, div_r};
  assign adv_next = (adv_sum >= {1'b0, uni}) ? UW'(adv_sum - {1'b0, uni}) : UW'(adv_sum);

  // divider launches
  always_comb begin
    div_load = 1'b0;
    div_long = 1'b0;
    div_num  = '0;
    div_den  = uni;
    div_to   = S_IDLE;
    case (state)
      S_CHECK: begin
        if (!exhausted && started_flag) begin
          div_load = 1'b1;
          div_num  = 64'(current_index);
          div_to   = S_SPLIT;
        end
      end
      S_MUL2: begin
        if (mcnt == 3'd3) begin
          div_load = 1'b1;
          div_long = 1'b1;
          div_num  = mix_out;
          div_to   = S_DRAW;
        end
      end
      S_GCD: begin
        if (gm != '0) begin
          div_load = 1'b1;
          div_num  = 64'(gx);
          div_den  = gm;
          div_to   = S_GCD_REM;
        end
      end
      S_SPLIT: begin
        div_load = 1'b1;
        div_num  = 64'(div_r);
        div_den  = ucnt;
        div_to   = S_UDIV;
      end
      S_UDIV: begin
        div_load = 1'b1;
        div_num  = 64'(div_r);
        div_den  = UW'(p_eff);
        div_to   = S_DIGIT;
      end
      S_DIGIT: begin
        div_load = 1'b1;
        if (dcnt == 2'(DIG_N - 1)) begin
          div_num = 64'(sc);
          div_den = UW'(q_val);
          div_to  = S_SURF;
        end else begin
          div_num = div_q;
          div_den = UW'(p_eff);
          div_to  = S_DIGIT;
        end
      end
      S_SURF: begin
        div_load = 1'b1;
        if (dcnt == 2'd2) begin
          div_num = 64'(walk_step);
          div_to  = S_ADV;
        end else begin
          div_num = div_q;
          div_den = UW'(q_val);
          div_to  = S_SURF;
        end
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (req_go) state_next = S_POW;
      S_POW:     if (mcnt == 3'(U_DIGITS - 1)) state_next = S_SIZE;
      S_SIZE:    if (mcnt == 3'd3) state_next = S_CHECK;
      S_CHECK: begin
        if (exhausted) begin
          state_next = S_IDLE;
        end else if (!started_flag) begin
          state_next = S_MIX_ADD;
        end
      end
      S_MIX_ADD: state_next = S_MUL1;
      S_MUL1:    if (mcnt == 3'd3) state_next = S_MUL2;
      S_MUL2:    state_next = S_MUL2;
      S_DIV:     if (div_cnt == 7'd1) state_next = div_ret;
      S_DRAW:    state_next = draw ? S_GCD : S_MIX_ADD;
      S_GCD:     if (gm == '0 && gx == UW'(1)) state_next = S_CHECK;
      S_GCD_REM: state_next = S_GCD;
      S_SPLIT:   state_next = S_SPLIT;
      S_UDIV:    state_next = S_UDIV;
      S_DIGIT:   state_next = S_DIGIT;
      S_SURF:    state_next = S_SURF;
      S_ADV:     state_next = S_OUT;
      S_OUT:     if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
    if (div_load) begin
      state_next = S_DIV;
    end
  end

  // handshake outputs
  always_comb begin
    request.ready  = (state == S_IDLE);
    sample.valid   = out_valid;
    sample.payload = out_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      prime_modulus <= PRIME_MIN;
      seed_value    <= '0;
      sample_budget <= 32'd1;
      rng_state     <= '0;
      walk_offset   <= '0;
      walk_step     <= '0;
      current_index <= '0;
      samples_done  <= '0;
      started_flag  <= 1'b0;
      out_valid     <= 1'b0;
      draw          <= 1'b0;
      mcnt          <= '0;
      dcnt          <= '0;
      div_cnt       <= '0;
      div_ret       <= S_IDLE;
    end else begin
      state <= state_next;

      if (sample.valid && sample.ready) begin
        out_valid <= 1'b0;
      end

      // divider load and iteration
      if (div_load) begin
        div_r   <= '0;
        div_d   <= div_den;
        div_ret <= div_to;
        if (div_long) begin
          div_q   <= div_num;
          div_cnt <= 7'd64;
        end else begin
          div_q   <= {div_num[UW-1:0], {PAD{1'b0}}};
          div_cnt <= 7'(UW);
        end
      end

      case (state)
        S_IDLE: begin
          if (req_go) begin
            ucnt <= UW'(1);
            mcnt <= '0;
          end
        end
        S_POW: begin
          ucnt <= pow_prod[UW-1:0];
          mcnt <= (mcnt == 3'(U_DIGITS - 1)) ? 3'd0 : mcnt + 3'd1;
        end
        S_SIZE: begin
          uni  <= size_prod[UW-1:0];
          mcnt <= mcnt + 3'd1;
        end
        S_CHECK: begin
          budget <= bud_cl;
          draw   <= 1'b0;
        end
        S_MIX_ADD: begin
          rng_state <= mix_sum;
          mul_a     <= mix_sum ^ (mix_sum >> MIX_SH1);
          acc       <= '0;
          mcnt      <= '0;
        end
        S_MUL1: begin
          mcnt <= mcnt + 3'd1;
          if (mcnt == 3'd3) begin
            mul_a <= nacc ^ (nacc >> MIX_SH2);
            acc   <= '0;
            mcnt  <= '0;
          end else begin
            acc <= nacc;
          end
        end
        S_MUL2: begin
          acc  <= nacc;
          mcnt <= mcnt + 3'd1;
        end
        S_DIV: begin
          div_cnt <= div_cnt - 7'd1;
          div_q   <= {div_q[62:0], div_ge};
          div_r   <= div_ge ? div_diff[UW-1:0] : div_sh[UW-1:0];
        end
        S_DRAW: begin
          if (!draw) begin
            walk_offset <= div_r;
            draw        <= 1'b1;
          end else begin
            // zero step becomes one
            walk_step <= (div_r == '0) ? UW'(1) : div_r;
            gx        <= (div_r == '0) ? UW'(1) : div_r;
            gm        <= uni;
          end
        end
        S_GCD: begin
          if (gm == '0) begin
            if (gx == UW'(1)) begin
              current_index <= walk_offset;
              started_flag  <= 1'b1;
            end else begin
              // next candidate, wrapping to one at the universe
              if (walk_step + UW'(1) == uni) begin
                walk_step <= UW'(1);
                gx        <= UW'(1);
              end else begin
                walk_step <= walk_step + UW'(1);
                gx        <= walk_step + UW'(1);
              end
              gm <= uni;
            end
          end
        end
        S_GCD_REM: begin
          gx <= gm;
          gm <= div_r;
        end
        S_SPLIT: begin
          idx <= div_r;
        end
        S_UDIV: begin
          sc        <= div_q[UW-1:0];
          digits[0] <= '0;
          digits[1] <= '0;
          digits[2] <= '0;
          dcnt      <= '0;
        end
        S_DIGIT: begin
          digits[dcnt] <= div_r[4:0];
          dcnt         <= (dcnt == 2'(DIG_N - 1)) ? 2'd0 : dcnt + 2'd1;
        end
        S_SURF: begin
          surf[dcnt] <= 5'd1 + div_r[4:0];
          if (dcnt == 2'd2) begin
            lambda <= div_q[4:0] + 5'd2;
          end else begin
            dcnt <= dcnt + 2'd1;
          end
        end
        S_ADV: begin
          current_index <= adv_next;
          samples_done  <= samples_done + 32'd1;
          last          <= (samples_done + 32'd1 == budget);
        end
        S_OUT: begin
          if (out_free) begin
            out_valid             <= 1'b1;
            out_data.sample_index <= 32'(idx);
            out_data.lambda_value <= lambda;
            out_data.y_value      <= surf[2];
            out_data.z_value      <= surf[1];
            out_data.w_value      <= surf[0];
            out_data.digit_zero   <= digits[0];
            out_data.digit_one    <= digits[1];
            out_data.digit_two    <= digits[2];
            out_data.last_sample  <= last;
          end
        end
        default: begin
        end
      endcase

      // configuration writes are to arrive only while idle; the block does not enforce it
      if (cfg_write) begin
        unique case (cfg_index)
          REG_PRIME:  prime_modulus <= cfg_data[4:0];
          REG_SEED: begin
            seed_value <= cfg_data;
            if (!started_flag) begin
              rng_state <= cfg_data;
            end
          end
          REG_BUDGET: sample_budget <= cfg_data[31:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire
